/* src/ncol_pkg.sv */
package ncol_pkg;

  localparam int ID_W   = 16;
  localparam int CW     = 32;
  localparam int EW     = CW - 1;
  localparam int NW     = 16;
  localparam int REL_W  = CW + 1;
  localparam int MAG_W  = CW + 1;
  localparam int D_W    = CW + 2;
  localparam int OV_W   = CW + 2;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int QW     = 15;
  localparam int NUM_W  = MAG_W + QW;
  localparam int SAT_W  = CW + 3;
  localparam int FRAC_N = 14;
  localparam int CNT_W  = 6;

  localparam logic [QW-1:0]    ONE_Q   = QW'(16384);
  localparam logic [ROOT_W-1:0] EPS_Q  = ROOT_W'(7);
  localparam logic [SQ_W-1:0]  HALF_N  = SQ_W'(8192);

  localparam logic signed [SAT_W-1:0] SAT_HI = {{(SAT_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] SAT_LO = {{(SAT_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_SS,
    MODE_SB,
    MODE_BB
  } mode_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_HOLD,
    OP_LOAD,
    OP_PREP,
    OP_PREP2,
    OP_MUL_SQ,
    OP_SQACC,
    OP_CHK,
    OP_SQRT_STEP,
    OP_NEAR,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_MUL_SC,
    OP_SCACC,
    OP_FIN
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_PREP2,
    S_SQ,
    S_CHK,
    S_SQRT,
    S_NEAR,
    S_DIV,
    S_SCALE,
    S_FIN
  } st_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic  overlap;
    mode_t mode;
    logic  near;
    logic  out_full;
  } sts_t;

  function automatic logic signed [CW-1:0] sat_c(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] r;
    if (v > SAT_HI) r = SAT_HI;
    else if (v < SAT_LO) r = SAT_LO;
    else r = v;
    return r[CW-1:0];
  endfunction

endpackage

/* src/ncol_in_if.sv */
interface ncol_in_if import ncol_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 pair_last;
  logic                 shape_kind;
  logic [ID_W-1:0]      body_id;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic signed [CW-1:0] pos_z;
  logic [EW-1:0]        extent_x;
  logic [EW-1:0]        extent_y;
  logic [EW-1:0]        extent_z;

  modport source (output valid, pair_last, shape_kind, body_id, pos_x, pos_y, pos_z,
                  extent_x, extent_y, extent_z, input ready);
  modport sink (input valid, pair_last, shape_kind, body_id, pos_x, pos_y, pos_z,
                extent_x, extent_y, extent_z, output ready);
endinterface

/* src/ncol_out_if.sv */
interface ncol_out_if import ncol_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 collided;
  logic [ID_W-1:0]      first_id;
  logic [ID_W-1:0]      second_id;
  logic signed [NW-1:0] normal_x;
  logic signed [NW-1:0] normal_y;
  logic signed [NW-1:0] normal_z;
  logic signed [CW-1:0] depth;
  logic signed [CW-1:0] contact_x;
  logic signed [CW-1:0] contact_y;
  logic signed [CW-1:0] contact_z;

  modport source (output valid, collided, first_id, second_id, normal_x, normal_y, normal_z,
                  depth, contact_x, contact_y, contact_z, input ready);
  modport sink (input valid, collided, first_id, second_id, normal_x, normal_y, normal_z,
                depth, contact_x, contact_y, contact_z, output ready);
endinterface

/* src/narrow_phase_collision_test.sv */
// channel | dir | transfer when       | payload
// in_ch   | in  | valid & ready       | pair_last, shape_kind, body_id, pos, extent
// out_ch  | out | valid & ready       | collided, ids, normal, depth, contact
//
// a holding item (pair_last low) is stored as the held body and gives no result
// a test item holds the input through load, prep, the squares (skipped for box-box),
// the bit-serial square root (34 steps, skipped for box-box and for no overlap), the
// three divisions (15 quotient steps each, skipped near zero distance) and, for two
// spheres, the contact scaling
// synchronous reset clears the held body to a zero sphere with id 0, no transfer in reset
// the result sits in an output register; a new item is taken while it waits,
// and only the next test result waits for that register to drain
module narrow_phase_collision_test import ncol_pkg::*; (
  input logic        clk,
  input logic        rst,
  ncol_in_if.sink    in_ch,
  ncol_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic idle;

  // sequencer: walks load, squares, root, divides and contact scaling
  ncol_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid & ~rst),
    .in_last  (in_ch.pair_last),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle)
  );

  // held body, shared multiplier, root and divide units, output register
  ncol_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // items are only taken while the sequencer is idle and out of reset
  assign in_ch.ready = idle & ~rst;

endmodule

/* src/ncol_ctrl.sv */
module ncol_ctrl import ncol_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_last,
  input  sts_t sts,
  output cmd_t cmd,
  output logic idle
);

  st_t              state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       idx, idx_next;
  logic             ph, ph_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      idx   <= '0;
      ph    <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      idx   <= idx_next;
      ph    <= ph_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    idx_next   = idx;
    ph_next    = ph;
    cmd.op     = OP_NONE;
    cmd.idx    = idx;
    idle       = 1'b0;
    unique case (state)
      S_IDLE: begin
        idle = 1'b1;
        if (in_valid) begin
          if (in_last) begin
            cmd.op     = OP_LOAD;
            state_next = S_PREP;
          end else begin
            cmd.op = OP_HOLD;
          end
        end
      end
      S_PREP: begin
        cmd.op     = OP_PREP;
        state_next = S_PREP2;
      end
      S_PREP2: begin
        cmd.op   = OP_PREP2;
        idx_next = '0;
        ph_next  = 1'b0;
        state_next = (sts.mode == MODE_BB) ? S_CHK : S_SQ;
      end
      S_SQ: begin
        cmd.op  = ph ? OP_SQACC : OP_MUL_SQ;
        ph_next = ~ph;
        if (ph) begin
          if (idx == 2'd3) state_next = S_CHK;
          else idx_next = idx + 2'd1;
        end
      end
      S_CHK: begin
        cmd.op     = OP_CHK;
        cnt_next   = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        if (!sts.overlap || sts.mode == MODE_BB) begin
          state_next = S_FIN;
        end else begin
          cmd.op   = OP_SQRT_STEP;
          cnt_next = cnt + CNT_W'(1);
          if (cnt == CNT_W'(ROOT_W - 1)) state_next = S_NEAR;
        end
      end
      S_NEAR: begin
        cmd.op   = OP_NEAR;
        idx_next = '0;
        cnt_next = '0;
        ph_next  = 1'b0;
        if (!sts.near) state_next = S_DIV;
        else if (sts.mode == MODE_SS) state_next = S_SCALE;
        else state_next = S_FIN;
      end
      S_DIV: begin
        cnt_next = cnt + CNT_W'(1);
        if (cnt == '0) begin
          cmd.op = OP_DIV_INIT;
        end else if (cnt == CNT_W'(QW + 1)) begin
          cmd.op   = OP_DIV_END;
          cnt_next = '0;
          if (idx == 2'd2) begin
            idx_next   = '0;
            state_next = (sts.mode == MODE_SS) ? S_SCALE : S_FIN;
          end else begin
            idx_next = idx + 2'd1;
          end
        end else begin
          cmd.op = OP_DIV_STEP;
        end
      end
      S_SCALE: begin
        cmd.op  = ph ? OP_SCACC : OP_MUL_SC;
        ph_next = ~ph;
        if (ph) begin
          if (idx == 2'd2) state_next = S_FIN;
          else idx_next = idx + 2'd1;
        end
      end
      S_FIN: begin
        if (!sts.out_full) begin
          cmd.op     = OP_FIN;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* src/ncol_dp.sv */
module ncol_dp import ncol_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  output sts_t         sts,
  ncol_in_if.sink      in_ch,
  ncol_out_if.source   out_ch
);

  // held body
  logic                 h_shape;
  logic [ID_W-1:0]      h_id;
  logic signed [CW-1:0] h_pos [3];
  logic [EW-1:0]        h_ext [3];

  // working operands: a is the sphere or first box, b the other body
  mode_t                mode;
  logic                 neg;
  logic [ID_W-1:0]      id1, id2;
  logic signed [CW-1:0] pa [3];
  logic signed [CW-1:0] pb [3];
  logic [EW-1:0]        ea [3];
  logic [EW-1:0]        eb [3];

  logic signed [REL_W-1:0] rel [3];
  logic [MAG_W-1:0]        lim;
  logic [MAG_W-1:0]        dmag [3];
  logic                    dneg [3];
  logic signed [CW-1:0]    cl [3];
  logic signed [OV_W-1:0]  ov [3];

  logic [SQ_W-1:0]   prod;
  logic [SUM_W-1:0]  acc;
  logic [SQ_W-1:0]   limsq;
  logic              overlap;
  logic [SUM_W-1:0]  rad;
  logic [ROOT_W-1:0] root;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] drem;
  logic [QW-1:0]     dlow;
  logic [QW-1:0]     quo;
  logic [QW-1:0]     nmag [3];
  logic              nneg [3];
  logic signed [CW-1:0] cr [3];

  logic                 o_valid;
  logic                 o_coll;
  logic [ID_W-1:0]      o_id1, o_id2;
  logic signed [NW-1:0] o_n [3];
  logic signed [CW-1:0] o_depth;
  logic signed [CW-1:0] o_c [3];

  // combinational helpers
  logic signed [CW-1:0]    i_pos [3];
  logic [EW-1:0]           i_ext [3];
  logic signed [REL_W-1:0] rel_c [3];
  logic [MAG_W-1:0]        lim_c;
  logic signed [REL_W-1:0] e_s [3];
  logic signed [REL_W-1:0] cl_c [3];
  logic signed [D_W-1:0]   d_c [3];
  logic [MAG_W-1:0]        relmag [3];
  logic signed [OV_W-1:0]  ov_c [3];
  logic [MAG_W-1:0]        mula, mulb;
  logic [MAG_W-1:0]        sc;
  logic [SQ_W-1:0]         sc_full;
  logic signed [SAT_W-1:0] cs;
  logic [REM_W-1:0]        remt, trial;
  logic [NUM_W-1:0]        num_c;
  logic [ROOT_W:0]         dt;
  logic                    dge;
  logic                    near_c;
  logic [1:0]              near_sel;
  logic                    ld_swap;
  logic [1:0]              bax;
  logic signed [NW-1:0]    nf [3];
  logic signed [CW-1:0]    cf [3];
  logic signed [CW-1:0]    depth_f;
  logic signed [REL_W-1:0] mid_s;

  always_comb begin
    i_pos[0] = in_ch.pos_x;    i_pos[1] = in_ch.pos_y;    i_pos[2] = in_ch.pos_z;
    i_ext[0] = in_ch.extent_x; i_ext[1] = in_ch.extent_y; i_ext[2] = in_ch.extent_z;
    // box held, sphere arriving: solved as sphere-box with the bodies swapped
    ld_swap = h_shape & ~in_ch.shape_kind;
    for (int i = 0; i < 3; i++) begin
      if (mode == MODE_SB) rel_c[i] = REL_W'(pa[i]) - REL_W'(pb[i]);
      else rel_c[i] = REL_W'(pb[i]) - REL_W'(pa[i]);
      e_s[i] = $signed({2'b00, eb[i]});
      if (rel[i] > e_s[i]) cl_c[i] = e_s[i];
      else if (rel[i] < -e_s[i]) cl_c[i] = -e_s[i];
      else cl_c[i] = rel[i];
      if (mode == MODE_SB) d_c[i] = D_W'(rel[i]) - D_W'(cl_c[i]);
      else d_c[i] = D_W'(rel[i]);
      relmag[i] = rel[i][REL_W-1] ? MAG_W'(-rel[i]) : MAG_W'(rel[i]);
      ov_c[i] = $signed(OV_W'(ea[i]) + OV_W'(eb[i]) - OV_W'(relmag[i]));
    end
    if (mode == MODE_SB) lim_c = MAG_W'(ea[0]);
    else lim_c = MAG_W'(ea[0]) + MAG_W'(eb[0]);

    // near zero distance: up for two spheres, else largest offset, later axis on ties
    if (mode == MODE_SS) near_sel = 2'd1;
    else if (relmag[0] > relmag[1] && relmag[0] > relmag[2]) near_sel = 2'd0;
    else if (relmag[1] > relmag[2]) near_sel = 2'd1;
    else near_sel = 2'd2;

    if (cmd.op == OP_MUL_SC) begin
      mula = MAG_W'(nmag[cmd.idx]);
      mulb = MAG_W'(ea[0]);
    end else begin
      mula = (cmd.idx == 2'd3) ? lim : dmag[cmd.idx];
      mulb = mula;
    end

    // rounded |n| * radius, then signed offset from the sphere centre
    sc_full = prod + HALF_N;
    sc      = sc_full[FRAC_N +: MAG_W];
    if (nneg[cmd.idx]) cs = SAT_W'(pa[cmd.idx]) - SAT_W'(sc);
    else cs = SAT_W'(pa[cmd.idx]) + SAT_W'(sc);

    remt  = {rem[REM_W-3:0], rad[SUM_W-1 -: 2]};
    trial = REM_W'({root, 2'b01});

    num_c = {1'b0, dmag[cmd.idx], {(QW-1){1'b0}}} + NUM_W'(root >> 1);
    dt    = {drem, dlow[QW-1]};
    dge   = dt >= {1'b0, root};

    near_c = root <= EPS_Q;

    // box-box axis of least overlap, earlier axis on ties
    if (ov[0] <= ov[1] && ov[0] <= ov[2]) bax = 2'd0;
    else if (ov[1] <= ov[2]) bax = 2'd1;
    else bax = 2'd2;

    for (int i = 0; i < 3; i++) begin
      mid_s = REL_W'(pa[i]) + REL_W'(pb[i]);
      if (mode == MODE_BB) begin
        if (bax == 2'(i)) nf[i] = (rel[i] > 0) ? NW'(ONE_Q) : -NW'(ONE_Q);
        else nf[i] = '0;
        cf[i] = CW'(mid_s >>> 1);
      end else begin
        nf[i] = nneg[i] ? -$signed(NW'(nmag[i])) : $signed(NW'(nmag[i]));
        if (neg) nf[i] = -nf[i];
        if (mode == MODE_SB) cf[i] = sat_c(SAT_W'(pb[i]) + SAT_W'(cl[i]));
        else cf[i] = cr[i];
      end
    end
    if (mode == MODE_BB) depth_f = sat_c(SAT_W'(ov[bax]));
    else depth_f = sat_c($signed(SAT_W'(lim)) - $signed(SAT_W'(root)));
  end

  assign sts.overlap  = overlap;
  assign sts.mode     = mode;
  assign sts.near     = near_c;
  assign sts.out_full = o_valid & ~out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_shape <= 1'b0;
      h_id    <= '0;
      for (int i = 0; i < 3; i++) begin
        h_pos[i] <= '0;
        h_ext[i] <= '0;
      end
      o_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_FIN) o_valid <= 1'b1;
      else if (o_valid && out_ch.ready) o_valid <= 1'b0;
      case (cmd.op)
        OP_HOLD: begin
          h_shape <= in_ch.shape_kind;
          h_id    <= in_ch.body_id;
          for (int i = 0; i < 3; i++) begin
            h_pos[i] <= i_pos[i];
            h_ext[i] <= i_ext[i];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        neg <= ld_swap;
        id1 <= ld_swap ? in_ch.body_id : h_id;
        id2 <= ld_swap ? h_id : in_ch.body_id;
        for (int i = 0; i < 3; i++) begin
          pa[i] <= ld_swap ? i_pos[i] : h_pos[i];
          ea[i] <= ld_swap ? i_ext[i] : h_ext[i];
          pb[i] <= ld_swap ? h_pos[i] : i_pos[i];
          eb[i] <= ld_swap ? h_ext[i] : i_ext[i];
        end
        unique case ({h_shape, in_ch.shape_kind}) inside
          2'b00:        mode <= MODE_SS;
          2'b01, 2'b10: mode <= MODE_SB;
          default:      mode <= MODE_BB;
        endcase
      end
      OP_PREP: begin
        for (int i = 0; i < 3; i++) rel[i] <= rel_c[i];
        lim <= lim_c;
      end
      OP_PREP2: begin
        for (int i = 0; i < 3; i++) begin
          dneg[i] <= d_c[i][D_W-1];
          dmag[i] <= d_c[i][D_W-1] ? MAG_W'(-d_c[i]) : MAG_W'(d_c[i]);
          cl[i]   <= CW'(cl_c[i]);
          ov[i]   <= ov_c[i];
        end
      end
      OP_MUL_SQ, OP_MUL_SC: prod <= mula * mulb;
      OP_SQACC: begin
        if (cmd.idx == 2'd3) limsq <= prod;
        else if (cmd.idx == 2'd0) acc <= SUM_W'(prod);
        else acc <= acc + SUM_W'(prod);
      end
      OP_CHK: begin
        if (mode == MODE_BB) overlap <= (ov[0] > 0) && (ov[1] > 0) && (ov[2] > 0);
        else overlap <= acc <= SUM_W'(limsq);
        rad  <= acc;
        root <= '0;
        rem  <= '0;
      end
      OP_SQRT_STEP: begin
        rad <= {rad[SUM_W-3:0], 2'b00};
        if (remt >= trial) begin
          rem  <= remt - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= remt;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      OP_NEAR: begin
        for (int i = 0; i < 3; i++) begin
          nmag[i] <= (near_c && near_sel == 2'(i)) ? ONE_Q : '0;
          nneg[i] <= near_c && near_sel == 2'(i) && mode != MODE_SS && !(rel[i] > 0);
        end
      end
      OP_DIV_INIT: begin
        drem <= ROOT_W'(num_c[NUM_W-1:QW]);
        dlow <= num_c[QW-1:0];
        quo  <= '0;
      end
      OP_DIV_STEP: begin
        drem <= dge ? ROOT_W'(dt - {1'b0, root}) : ROOT_W'(dt);
        dlow <= {dlow[QW-2:0], 1'b0};
        quo  <= {quo[QW-2:0], dge};
      end
      OP_DIV_END: begin
        nmag[cmd.idx] <= quo;
        nneg[cmd.idx] <= dneg[cmd.idx];
      end
      OP_SCACC: cr[cmd.idx] <= sat_c(cs);
      OP_FIN: begin
        o_coll <= overlap;
        o_id1  <= id1;
        o_id2  <= id2;
        o_depth <= overlap ? depth_f : '0;
        for (int i = 0; i < 3; i++) begin
          o_n[i] <= overlap ? nf[i] : '0;
          o_c[i] <= overlap ? cf[i] : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid     = o_valid;
  assign out_ch.collided  = o_coll;
  assign out_ch.first_id  = o_id1;
  assign out_ch.second_id = o_id2;
  assign out_ch.normal_x  = o_n[0];
  assign out_ch.normal_y  = o_n[1];
  assign out_ch.normal_z  = o_n[2];
  assign out_ch.depth     = o_depth;
  assign out_ch.contact_x = o_c[0];
  assign out_ch.contact_y = o_c[1];
  assign out_ch.contact_z = o_c[2];

endmodule

/* verif/narrow_phase_collision_test_tb.sv */
`timescale 1ns / 1ps

module narrow_phase_collision_test_tb;
  import ncol_pkg::*;

  typedef logic signed [63:0] s64;

  // one body as it crosses the input channel
  typedef struct {
    logic                 last;
    logic                 kind;
    logic [ID_W-1:0]      id;
    logic signed [CW-1:0] pos[3];
    logic [EW-1:0]        ext[3];
  } body_t;

  // one contact as it leaves the block
  typedef struct {
    logic                 coll;
    logic [ID_W-1:0]      fid;
    logic [ID_W-1:0]      sid;
    logic signed [NW-1:0] n[3];
    logic signed [CW-1:0] depth;
    logic signed [CW-1:0] c[3];
  } contact_t;

  typedef struct {
    body_t    b;
    bit       typed;
    contact_t want;
  } stim_row_t;

  localparam s64 SAT_MAX    = 64'sd2147483647;
  localparam s64 SAT_MIN    = -64'sd2147483648;
  localparam s64 NEAR_EPS   = 64'sd7;
  localparam s64 UNIT       = 64'sd16384;
  localparam int RAND_ITEMS = 1500;
  localparam int HOLD_OFF   = 600;
  localparam longint LIMIT  = 1000000;
  localparam logic SPHERE   = 1'b0;
  localparam logic BOX      = 1'b1;
  localparam logic HOLD     = 1'b0;
  localparam logic TEST     = 1'b1;

  logic clk;
  logic rst;

  ncol_in_if  in_ch();
  ncol_out_if out_ch();

  narrow_phase_collision_test i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // predictor state: the body that a test item is measured against
  body_t    held_body;
  contact_t contact_q[$];
  stim_row_t stim_rows[$];
  int       accepted;
  int       phase;
  int       errors;
  longint   cycles;

  // ---------------------------------------------------------------------
  // predictor arithmetic, all wide enough that nothing wraps
  // ---------------------------------------------------------------------
  function automatic logic [63:0] abs64(s64 v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [127:0] sq_sum(s64 a, s64 b, s64 c);
    return {64'd0, abs64(a)} * {64'd0, abs64(a)} + {64'd0, abs64(b)} * {64'd0, abs64(b)}
         + {64'd0, abs64(c)} * {64'd0, abs64(c)};
  endfunction

  // square root rounded down, one bit per step from the top
  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  // q2.14 component of d / separation, halves away from zero
  function automatic s64 norm_comp(s64 v, logic [63:0] sep);
    logic [63:0] q;
    q = (abs64(v) * 64'd16384 + sep / 2) / sep;
    return v < 0 ? -s64'(q) : s64'(q);
  endfunction

  function automatic s64 scale_norm(s64 n, logic [63:0] r);
    logic [63:0] q;
    q = (abs64(n) * r + 64'd8192) >> 14;
    return n < 0 ? -s64'(q) : s64'(q);
  endfunction

  function automatic s64 unit_sign(s64 v);
    return v > 0 ? UNIT : -UNIT;
  endfunction

  function automatic logic signed [CW-1:0] sat32(s64 v);
    if (v > SAT_MAX) return SAT_MAX[CW-1:0];
    if (v < SAT_MIN) return SAT_MIN[CW-1:0];
    return v[CW-1:0];
  endfunction

  function automatic contact_t no_contact(logic [ID_W-1:0] fid, logic [ID_W-1:0] sid);
    contact_t r;
    r.coll  = 1'b0;
    r.fid   = fid;
    r.sid   = sid;
    r.depth = '0;
    for (int i = 0; i < 3; i++) begin
      r.n[i] = '0;
      r.c[i] = '0;
    end
    return r;
  endfunction

  // sphere against box, measured from the closest point of the box
  function automatic contact_t sphere_box(body_t s, body_t b);
    contact_t    r;
    s64          rel[3];
    s64          cl[3];
    s64          d[3];
    s64          e;
    logic [63:0] rad;
    logic [63:0] sep;
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] az;
    r   = no_contact(s.id, b.id);
    rad = 64'(s.ext[0]);
    for (int i = 0; i < 3; i++) begin
      e      = s64'(b.ext[i]);
      rel[i] = s64'(s.pos[i]) - s64'(b.pos[i]);
      cl[i]  = rel[i] > e ? e : (rel[i] < -e ? -e : rel[i]);
      d[i]   = rel[i] - cl[i];
    end
    if (sq_sum(d[0], d[1], d[2]) > {64'd0, rad} * {64'd0, rad}) return r;
    sep    = isqrt(sq_sum(d[0], d[1], d[2]));
    r.coll = 1'b1;
    if (s64'(sep) > NEAR_EPS) begin
      for (int i = 0; i < 3; i++) r.n[i] = NW'(norm_comp(d[i], sep));
    end else begin
      // centre within the epsilon of the box: largest offset wins, later axis on a tie
      ax = abs64(rel[0]);
      ay = abs64(rel[1]);
      az = abs64(rel[2]);
      if (ax > ay && ax > az) r.n[0] = NW'(unit_sign(rel[0]));
      else if (ay > az)       r.n[1] = NW'(unit_sign(rel[1]));
      else                    r.n[2] = NW'(unit_sign(rel[2]));
    end
    r.depth = sat32(s64'(rad) - s64'(sep));
    for (int i = 0; i < 3; i++) r.c[i] = sat32(s64'(b.pos[i]) + cl[i]);
    return r;
  endfunction

  // expected contact of a test body against the held one
  function automatic contact_t predict_contact(body_t h, body_t t);
    contact_t    r;
    s64          d[3];
    s64          ov[3];
    s64          s;
    logic [63:0] rs;
    logic [63:0] sep;
    int          axis;
    r = no_contact(h.id, t.id);
    if (h.kind == SPHERE && t.kind == SPHERE) begin
      rs = 64'(h.ext[0]) + 64'(t.ext[0]);
      for (int i = 0; i < 3; i++) d[i] = s64'(t.pos[i]) - s64'(h.pos[i]);
      if (sq_sum(d[0], d[1], d[2]) <= {64'd0, rs} * {64'd0, rs}) begin
        sep    = isqrt(sq_sum(d[0], d[1], d[2]));
        r.coll = 1'b1;
        if (s64'(sep) > NEAR_EPS) begin
          for (int i = 0; i < 3; i++) r.n[i] = NW'(norm_comp(d[i], sep));
        end else begin
          r.n[1] = NW'(UNIT);
        end
        r.depth = sat32(s64'(rs) - s64'(sep));
        for (int i = 0; i < 3; i++)
          r.c[i] = sat32(s64'(h.pos[i]) + scale_norm(s64'(r.n[i]), 64'(h.ext[0])));
      end
    end else if (h.kind == SPHERE) begin
      r = sphere_box(h, t);
    end else if (t.kind == SPHERE) begin
      // box first: solved as sphere-box, then normal flipped
      r = sphere_box(t, h);
      for (int i = 0; i < 3; i++) r.n[i] = -r.n[i];
    end else begin
      for (int i = 0; i < 3; i++) begin
        d[i]  = s64'(t.pos[i]) - s64'(h.pos[i]);
        ov[i] = s64'(64'(h.ext[i]) + 64'(t.ext[i])) - s64'(abs64(d[i]));
      end
      if (ov[0] > 0 && ov[1] > 0 && ov[2] > 0) begin
        r.coll = 1'b1;
        if (ov[0] <= ov[1] && ov[0] <= ov[2]) axis = 0;
        else if (ov[1] <= ov[2])              axis = 1;
        else                                  axis = 2;
        r.depth   = sat32(ov[axis]);
        r.n[axis] = NW'(unit_sign(d[axis]));
        for (int i = 0; i < 3; i++) begin
          s      = s64'(h.pos[i]) + s64'(t.pos[i]);
          r.c[i] = sat32(s >>> 1);
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus construction
  // ---------------------------------------------------------------------
  function automatic body_t mk_body(logic last, logic kind, logic [ID_W-1:0] id,
                                    s64 px, s64 py, s64 pz, s64 ex, s64 ey, s64 ez);
    body_t b;
    b.last   = last;
    b.kind   = kind;
    b.id     = id;
    b.pos[0] = px[CW-1:0];
    b.pos[1] = py[CW-1:0];
    b.pos[2] = pz[CW-1:0];
    b.ext[0] = ex[EW-1:0];
    b.ext[1] = ey[EW-1:0];
    b.ext[2] = ez[EW-1:0];
    return b;
  endfunction

  function automatic contact_t mk_contact(logic coll, logic [ID_W-1:0] fid,
                                          logic [ID_W-1:0] sid, s64 nx, s64 ny, s64 nz,
                                          s64 dep, s64 cx, s64 cy, s64 cz);
    contact_t r;
    r.coll  = coll;
    r.fid   = fid;
    r.sid   = sid;
    r.n[0]  = NW'(nx);
    r.n[1]  = NW'(ny);
    r.n[2]  = NW'(nz);
    r.depth = dep[CW-1:0];
    r.c[0]  = cx[CW-1:0];
    r.c[1]  = cy[CW-1:0];
    r.c[2]  = cz[CW-1:0];
    return r;
  endfunction

  task automatic add_row(body_t b, bit typed, contact_t want);
    stim_row_t row;
    row.b     = b;
    row.typed = typed;
    row.want  = want;
    stim_rows.insert(stim_rows.size(), row);
  endtask

  // body scattered around a centre, offsets and extents within span
  function automatic body_t near_body(logic last, logic [CW-1:0] cen[3], int span);
    body_t b;
    b.last = last;
    b.kind = 1'($urandom_range(0, 1));
    b.id   = ID_W'($urandom_range(0, 65535));
    for (int i = 0; i < 3; i++) begin
      b.pos[i] = cen[i] + CW'(int'($urandom_range(0, 2 * span)) - span);
      b.ext[i] = EW'($urandom_range(0, span));
    end
    return b;
  endfunction

  // any bit pattern at all, kept as background noise
  function automatic body_t noise_body();
    body_t b;
    b.last = 1'($urandom_range(0, 1));
    b.kind = 1'($urandom_range(0, 1));
    b.id   = ID_W'($urandom);
    for (int i = 0; i < 3; i++) begin
      b.pos[i] = CW'($urandom);
      b.ext[i] = EW'($urandom);
    end
    return b;
  endfunction

  function automatic int sender_idle_pct();
    return phase == 0 ? 30 : (phase == 1 ? 86 : 0);
  endfunction

  function automatic int receiver_idle_pct();
    return phase == 0 ? 86 : (phase == 1 ? 30 : 0);
  endfunction

  // ---------------------------------------------------------------------
  // input driver: payload changes on the falling edge, transfer on the
  // rising edge; valid stays high between back-to-back items
  // ---------------------------------------------------------------------
  task automatic send_body(body_t b, bit typed, contact_t want);
    contact_t exp_c;
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.pair_last  <= b.last;
    in_ch.shape_kind <= b.kind;
    in_ch.body_id    <= b.id;
    in_ch.pos_x      <= b.pos[0];
    in_ch.pos_y      <= b.pos[1];
    in_ch.pos_z      <= b.pos[2];
    in_ch.extent_x   <= b.ext[0];
    in_ch.extent_y   <= b.ext[1];
    in_ch.extent_z   <= b.ext[2];
    do @(posedge clk); while (!in_ch.ready);
    // transfer taken: holding items update the predictor, tests expect one contact
    if (b.last == HOLD) begin
      held_body = b;
    end else begin
      exp_c = typed ? want : predict_contact(held_body, b);
      contact_q.insert(contact_q.size(), exp_c);
    end
    accepted++;
    phase = accepted < RAND_ITEMS / 3 ? 0 : (accepted < 2 * RAND_ITEMS / 3 ? 1 : 2);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // output side: ready set on the falling edge, with one long hold-off
  // when the last phase starts so the block backs up into its input
  // ---------------------------------------------------------------------
  int holdoff_left;
  bit holdoff_done;

  always @(negedge clk) begin
    if (phase == 2 && !holdoff_done) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLD_OFF;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= $urandom_range(0, 99) >= receiver_idle_pct();
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  // result checker, field by field against the oldest expectation
  always @(posedge clk) begin
    contact_t w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (contact_q.size() == 0) begin
        report("unexpected result, collided", out_ch.collided, 0);
      end else begin
        w = contact_q.pop_front();
        if (out_ch.collided !== w.coll) report("collided", out_ch.collided, w.coll);
        if (out_ch.first_id !== w.fid) report("first_id", out_ch.first_id, w.fid);
        if (out_ch.second_id !== w.sid) report("second_id", out_ch.second_id, w.sid);
        if (out_ch.normal_x !== w.n[0]) report("normal_x", out_ch.normal_x, w.n[0]);
        if (out_ch.normal_y !== w.n[1]) report("normal_y", out_ch.normal_y, w.n[1]);
        if (out_ch.normal_z !== w.n[2]) report("normal_z", out_ch.normal_z, w.n[2]);
        if (out_ch.depth !== w.depth) report("depth", out_ch.depth, w.depth);
        if (out_ch.contact_x !== w.c[0]) report("contact_x", out_ch.contact_x, w.c[0]);
        if (out_ch.contact_y !== w.c[1]) report("contact_y", out_ch.contact_y, w.c[1]);
        if (out_ch.contact_z !== w.c[2]) report("contact_z", out_ch.contact_z, w.c[2]);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL narrow_phase_collision_test");
      $finish;
    end
  end

  initial begin
    logic [CW-1:0] cen[3];
    contact_t      none;
    body_t         hb;
    body_t         tb_body;
    int            pick;
    int            span;
    int            tests;

    clk              = 1'b0;
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.pair_last  = 1'b0;
    in_ch.shape_kind = 1'b0;
    in_ch.body_id    = '0;
    in_ch.pos_x      = '0;
    in_ch.pos_y      = '0;
    in_ch.pos_z      = '0;
    in_ch.extent_x   = '0;
    in_ch.extent_y   = '0;
    in_ch.extent_z   = '0;
    out_ch.ready     = 1'b0;
    accepted         = 0;
    phase            = 0;
    errors           = 0;
    cycles           = 0;
    holdoff_left     = 0;
    holdoff_done     = 1'b0;
    held_body        = mk_body(HOLD, SPHERE, 0, 0, 0, 0, 0, 0, 0);
    none             = no_contact(0, 0);

    // directed table; typed expectations only where obvious
    // test straight after reset, against the zero sphere with id 0
    add_row(mk_body(TEST, SPHERE, 5, 0, 0, 0, 0, 0, 0), 1,
            mk_contact(1, 0, 5, 0, 16384, 0, 0, 0, 0, 0));
    // touching the reset sphere at exactly the radius sum
    add_row(mk_body(TEST, SPHERE, 6, 'h10000, 0, 0, 'h10000, 0, 0), 0, none);
    // opposite corners of the coordinate range, no overlap
    add_row(mk_body(HOLD, SPHERE, 'hFFFF, SAT_MIN, SAT_MIN, SAT_MIN, 0, 0, 0), 0, none);
    add_row(mk_body(TEST, SPHERE, 1, SAT_MAX, SAT_MAX, SAT_MAX, 0, 0, 0), 1,
            mk_contact(0, 'hFFFF, 1, 0, 0, 0, 0, 0, 0, 0));
    // sphere of radius 2 at the origin, tested several times
    add_row(mk_body(HOLD, SPHERE, 10, 0, 0, 0, 'h20000, 0, 0), 0, none);
    add_row(mk_body(TEST, SPHERE, 11, 'h10000, 'h8000, -'h4000, 'h10000, 0, 0), 0, none);
    add_row(mk_body(TEST, BOX, 12, 'h30000, 0, 0, 'h10000, 'h10000, 'h10000), 0, none);
    // sphere centre inside the box with zero offsets: negative z
    add_row(mk_body(TEST, BOX, 13, 0, 0, 0, 'h10000, 'h20000, 'h30000), 1,
            mk_contact(1, 10, 13, 0, 0, -16384, 'h20000, 0, 0, 0));
    add_row(mk_body(TEST, BOX, 14, 'h40000, 'h40000, 0, 'h10000, 'h10000, 'h10000), 0, none);
    // unit box at the origin
    add_row(mk_body(HOLD, BOX, 20, 0, 0, 0, 'h10000, 'h10000, 'h10000), 0, none);
    // identical boxes: every overlap ties, x wins, zero offset is negative
    add_row(mk_body(TEST, BOX, 21, 0, 0, 0, 'h10000, 'h10000, 'h10000), 1,
            mk_contact(1, 20, 21, -16384, 0, 0, 'h20000, 0, 0, 0));
    // faces just touching: zero overlap is no contact
    add_row(mk_body(TEST, BOX, 22, 'h20000, 0, 0, 'h10000, 'h10000, 'h10000), 1,
            mk_contact(0, 20, 22, 0, 0, 0, 0, 0, 0, 0));
    // box then sphere: ids swapped, normal flipped
    add_row(mk_body(TEST, SPHERE, 23, 'h18000, 'h1000, 0, 'h10000, 0, 0), 0, none);
    add_row(mk_body(TEST, BOX, 24, 'h10000, 'h8000, 'h4000, 'h10000, 'h10000, 'h10000),
            0, none);
    // largest boxes at the top corner: depth saturates
    add_row(mk_body(HOLD, BOX, 30, SAT_MAX, SAT_MAX, SAT_MAX,
                    'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF), 0, none);
    add_row(mk_body(TEST, BOX, 31, SAT_MAX, SAT_MAX, SAT_MAX,
                    'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF), 0, none);
    add_row(mk_body(TEST, SPHERE, 32, SAT_MIN, SAT_MIN, SAT_MIN, 'h7FFFFFFF, 0, 0), 0, none);
    // largest spheres at opposite corners
    add_row(mk_body(HOLD, SPHERE, 40, SAT_MAX, SAT_MAX, SAT_MAX, 'h7FFFFFFF, 0, 0), 0, none);
    add_row(mk_body(TEST, SPHERE, 41, SAT_MIN, SAT_MIN, SAT_MIN,
                    'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF), 0, none);
    // centres closer than the epsilon: normal up
    add_row(mk_body(HOLD, SPHERE, 50, 0, 0, 0, 'h10000, 0, 0), 0, none);
    add_row(mk_body(TEST, SPHERE, 51, 3, 2, 1, 0, 0, 0), 1,
            mk_contact(1, 50, 51, 0, 16384, 0, 65533, 0, 'h10000, 0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (stim_rows[i]) send_body(stim_rows[i].b, stim_rows[i].typed, stim_rows[i].want);

    // random part: mostly hold-then-test pairs around a shared centre
    accepted = 0;
    phase    = 0;
    while (accepted < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        for (int i = 0; i < 3; i++)
          cen[i] = ($urandom_range(0, 3) == 0) ? CW'($urandom)
                                               : CW'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
        case ($urandom_range(0, 3))
          0: span = 1 << 12;
          1: span = 1 << 16;
          2: span = 1 << 18;
          default: span = 1 << 20;
        endcase
        hb = near_body(HOLD, cen, span);
        send_body(hb, 0, none);
        tests = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1;
        repeat (tests) begin
          tb_body = near_body(TEST, cen, span);
          // same centre now and then, to reach the near-zero normals
          if ($urandom_range(0, 9) == 0) tb_body.pos = hb.pos;
          send_body(tb_body, 0, none);
        end
      end else begin
        send_body(noise_body(), 0, none);
      end
    end
    in_ch.valid <= 1'b0;

    // drain, then let the block settle
    while (contact_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("PASS narrow_phase_collision_test");
    end else begin
      $display("FAIL narrow_phase_collision_test");
    end
    $finish;
  end

endmodule

/* sim.f */
src/ncol_pkg.sv
src/ncol_in_if.sv
src/ncol_out_if.sv
src/ncol_ctrl.sv
src/ncol_dp.sv
src/narrow_phase_collision_test.sv
verif/narrow_phase_collision_test_tb.sv
